@@ rtl/ksp_pkg.sv @@
// shared constants and types for the plucked-string voice
`default_nettype none

package ksp_pkg;

    localparam int DEF_MAX_PERIOD  = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int PERIOD_W    = 13;
    localparam int DAMP_W      = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 8;
    localparam int LFSR_W      = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_PERIOD = cfg_index_t'(0);
    localparam cfg_index_t REG_DAMP   = cfg_index_t'(1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(168);
    localparam logic [DAMP_W-1:0]   DAMP_RESET   = DAMP_W'(32768);

    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h1D87_2B41;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

endpackage

`default_nettype wire

@@ rtl/ksp_ram.sv @@
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module ksp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/ksp_noise.sv @@
// galois lfsr noise source scaled to the 0..5.0 sample range
`default_nettype none

module ksp_noise
    import ksp_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step,
    output logic      [SAMPLE_BITS-1:0] noise
);

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(5 << (SAMPLE_BITS - 3));

    logic [LFSR_W-1:0]         lfsr_reg;
    logic [LFSR_W-1:0]         lfsr_next;
    logic [SAMPLE_BITS+15:0]   scaled;

    always_comb begin
        lfsr_next = {1'b0, lfsr_reg[LFSR_W-1:1]};
        if (lfsr_reg[0]) begin
            lfsr_next = lfsr_next ^ LFSR_TAPS;
        end
        scaled = (SAMPLE_BITS+16)'(lfsr_next[LFSR_W-1:16]) * (SAMPLE_BITS+16)'(FULL_SCALE);
    end

    assign noise = scaled[SAMPLE_BITS+15:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED;
        end else if (step) begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/karplus_strong_pluck_voice.sv @@
// Plucked-string voice: one sample tick in, one damped string sample out.
//
// Channels: s_* carries one tick per transfer (pluck level in s_tdata bit 0),
// m_* returns one sample per tick (unsigned Q3.(SAMPLE_BITS-3), low bits of
// m_tdata). cfg_* writes the period (index 0) and damping gain (index 1);
// cfg_ready is always high and writes belong between ticks.
//
// Throughput: one tick at a time. An armed tick steps through accept, line
// read, multiply, write back and neighbor read, all on the single port
// pair of the delay-line ram. A rising pluck first walks the line with
// noise, one entry per cycle, over the clamped period. Before the first
// pluck a tick passes through the zero state and returns zero.
// Output: m_tvalid is registered from the write-back state for an armed
// tick, after any pluck fill, and from the zero state before the first pluck.
//
// Reset clears position, previous sample, edge detector and armed flag,
// reloads the noise seed and the default registers; the line holds no
// data until the first pluck fills it. A stalled receiver holds the sample
// in the output register and the voice waits before its next write back.
`default_nettype none

module karplus_strong_pluck_voice
    import ksp_pkg::*;
#(
    parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [S_TDATA_W-1:0]                s_tdata,   // [0] pluck
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int AW       = $clog2(MAX_PERIOD);
    localparam int PW       = (PERIOD_W > AW + 1) ? PERIOD_W : AW + 1;
    localparam int TW       = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MUL_W    = DAMP_W + SAMPLE_BITS + 1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX =
        SAMPLE_BITS'((5 << (SAMPLE_BITS - 3)) - 1);

    typedef enum logic [2:0] {
        IDLE,
        FILL,
        RD,
        MUL,
        WR,
        PREV,
        ZERO
    } state_t;

    state_t                  state_reg, state_next;
    logic [PERIOD_W-1:0]     period_reg;
    logic [DAMP_W-1:0]       damp_reg;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [SAMPLE_BITS-1:0]  prev_reg, prev_next;
    logic                    last_trig_reg, last_trig_next;
    logic                    armed_reg, armed_next;
    logic [AW-1:0]           fill_reg, fill_next;
    logic [MUL_W-1:0]        mult_reg, mult_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;

    logic [PW-1:0]           period_wide;
    logic [AW:0]             eff_p;
    logic [AW-1:0]           pos_eff;
    logic [AW-1:0]           prev_idx;
    logic [AW:0]             pos_inc;
    logic [SAMPLE_BITS:0]    shifted;
    logic [SAMPLE_BITS-1:0]  sat_v;
    logic                    slot_free;
    logic                    pluck;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SAMPLE_BITS-1:0]  ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic                    noise_step;
    logic [SAMPLE_BITS-1:0]  noise;

    ksp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PERIOD)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ksp_noise #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (noise_step),
        .noise   (noise)
    );

    assign pluck     = s_tdata[0];
    assign s_tready  = (state_reg == IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = TW'(sample_reg);
    assign cfg_ready = 1'b1;
    assign slot_free = !m_tvalid_reg || m_tready;

    // period clamped to 2..MAX_PERIOD
    always_comb begin
        period_wide = PW'(period_reg);
        if (period_wide < PW'(2)) begin
            period_wide = PW'(2);
        end else if (period_wide > PW'(MAX_PERIOD)) begin
            period_wide = PW'(MAX_PERIOD);
        end
        eff_p = period_wide[AW:0];
    end

    always_comb begin
        pos_eff  = ({1'b0, pos_reg} >= eff_p) ? '0 : pos_reg;
        prev_idx = (pos_reg == '0) ? AW'(eff_p - (AW+1)'(1)) : pos_reg - AW'(1);
        pos_inc  = {1'b0, pos_reg} + (AW+1)'(1);
        shifted  = mult_reg[MUL_W-1:DAMP_W];
        sat_v    = (shifted > (SAMPLE_BITS+1)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                            : shifted[SAMPLE_BITS-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        last_trig_next = last_trig_reg;
        armed_next     = armed_reg;
        fill_next      = fill_reg;
        mult_next      = mult_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        sample_next    = sample_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = sat_v;
        ram_raddr      = pos_eff;
        noise_step     = 1'b0;

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    last_trig_next = pluck;
                    if (pluck && !last_trig_reg) begin
                        state_next = FILL;
                        fill_next  = '0;
                        pos_next   = '0;
                        armed_next = 1'b1;
                    end else if (armed_reg) begin
                        state_next = RD;
                    end else begin
                        state_next = ZERO;
                    end
                end
            end
            FILL: begin
                ram_we     = 1'b1;
                ram_waddr  = fill_reg;
                ram_wdata  = noise;
                noise_step = 1'b1;
                if ({1'b0, fill_reg} == eff_p - (AW+1)'(1)) begin
                    state_next = RD;
                end else begin
                    fill_next = fill_reg + AW'(1);
                end
            end
            RD: begin
                pos_next   = pos_eff;
                ram_raddr  = pos_eff;
                state_next = MUL;
            end
            MUL: begin
                mult_next  = MUL_W'(damp_reg) *
                             MUL_W'((SAMPLE_BITS+1)'(ram_rdata) + (SAMPLE_BITS+1)'(prev_reg));
                state_next = WR;
            end
            WR: begin
                ram_raddr = prev_idx;
                if (slot_free) begin
                    ram_we        = 1'b1;
                    ram_waddr     = pos_reg;
                    ram_wdata     = sat_v;
                    m_tvalid_next = 1'b1;
                    sample_next   = sat_v;
                    state_next    = PREV;
                end
            end
            PREV: begin
                prev_next  = ram_rdata;
                pos_next   = (pos_inc >= eff_p) ? '0 : pos_inc[AW-1:0];
                state_next = IDLE;
            end
            ZERO: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    sample_next   = '0;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            period_reg    <= PERIOD_RESET;
            damp_reg      <= DAMP_RESET;
            pos_reg       <= '0;
            prev_reg      <= '0;
            last_trig_reg <= 1'b0;
            armed_reg     <= 1'b0;
            fill_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            last_trig_reg <= last_trig_next;
            armed_reg     <= armed_next;
            fill_reg      <= fill_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_DAMP:   damp_reg   <= cfg_data[DAMP_W-1:0];
                    default:    ;
                endcase
            end
        end
        mult_reg   <= mult_next;
        sample_reg <= sample_next;
    end

endmodule

`default_nettype wire

@@ rtl/ksp_checker.sv @@
// port-level checks for the plucked-string voice, bound to the top level
`default_nettype none

module ksp_checker
    import ksp_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [S_TDATA_W-1:0]             s_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX =
        SAMPLE_BITS'((5 << (SAMPLE_BITS - 3)) - 1);

    logic last_pluck_reg, last_pluck_next;
    logic plucked_reg, plucked_next;
    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    always_comb begin
        last_pluck_next = last_pluck_reg;
        plucked_next    = plucked_reg;
        if (s_xfer) begin
            last_pluck_next = s_tdata[0];
            if (s_tdata[0] && !last_pluck_reg) begin
                plucked_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pluck_reg <= 1'b0;
            plucked_reg    <= 1'b0;
        end else begin
            last_pluck_reg <= last_pluck_next;
            plucked_reg    <= plucked_next;
        end
    end

    // samples stay below full scale
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SAMPLE_BITS-1:0] <= SAMPLE_MAX)
        else $error("sample above full scale");

    // silent until the first pluck
    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !plucked_reg |-> m_tdata == '0)
        else $error("nonzero sample before first pluck");

    // s_tready is low after each accepted tick
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("tick accepted on back-to-back cycles");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind karplus_strong_pluck_voice ksp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ksp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
